@@ design/rc_serial_frame_parser_macros.svh @@
// ---------------------------------------------------------------------------
// RC serial frame parser assertion macros
// Shared concurrent assertion forms for the frame parser design.
// ---------------------------------------------------------------------------
`ifndef RC_SERIAL_FRAME_PARSER_MACROS_SVH
`define RC_SERIAL_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RCSFP_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("frame parser assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RCSFP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("frame parser assertion failed");

`endif

@@ design/rcsfp_pkg.sv @@
// ---------------------------------------------------------------------------
// RC serial frame parser package
// Request and response types of the shared subtract and compare unit.
// ---------------------------------------------------------------------------
package rcsfp_pkg;

	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
	} unit_req_t;

	typedef struct packed {
		logic [15:0] diff;
		logic        eq;
	} unit_rsp_t;

endpackage

@@ design/rcsfp_unit.sv @@
// ---------------------------------------------------------------------------
// RC serial frame parser shared unit
// One 16-bit subtractor whose zero flag also serves as the equality compare.
// ---------------------------------------------------------------------------
module rcsfp_unit import rcsfp_pkg::*; (
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic [15:0] diff;

	assign diff     = req.a - req.b;
	assign rsp.diff = diff;
	assign rsp.eq   = (diff == 16'h0000);

endmodule

@@ design/rc_serial_frame_parser.sv @@
// ---------------------------------------------------------------------------
// RC serial frame parser
// Hunts for a two-byte header, collects little-endian channel words and a
// checksum, and emits the channel values of each good frame or one error word.
// ---------------------------------------------------------------------------
// Channel   Handshake                 Payload
// input     in_valid / in_ready       rx_byte
// output    out_valid / out_ready     status, channel_index, channel_value,
//                                     last_of_run
// config    APB write, pready high    paddr, pwdata, prdata
//
// A matching header byte passes a test state and then a sum state, and any other
// byte in the hunt or the body passes the test state only, all through the one
// shared subtractor. The final checksum byte is tested, then each channel word
// takes a memory-read state and a send state, plus output stalls. A checksum
// error sends one word after the test. No byte is taken while a word is pending.
// Reset puts the parser in the first header hunt with no clearing pass.
// ---------------------------------------------------------------------------
`include "rc_serial_frame_parser_macros.svh"

module rc_serial_frame_parser import rcsfp_pkg::*; #(
	parameter int CHANNELS    = 14,
	parameter int FRAME_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        status,
	output logic [3:0]  channel_index,
	output logic [15:0] channel_value,
	output logic        last_of_run,
	output logic        out_valid,
	input  logic        out_ready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [5:0] SUM_END = 6'(FRAME_BYTES - 2);
	localparam logic [5:0] CAP_END = 6'(2 + 2 * CHANNELS);
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

	localparam logic [1:0] PH_HDR1 = 2'd0;
	localparam logic [1:0] PH_HDR2 = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_TEST = 5'b00010,
		S_SUM  = 5'b00100,
		S_LOAD = 5'b01000,
		S_SEND = 5'b10000
	} state_t;

	state_t          state_q;
	logic [7:0]      first_hdr_q;
	logic [7:0]      second_hdr_q;
	logic [7:0]      byte_q;
	logic [1:0]      phase_q;
	logic [5:0]      count_q;
	logic [15:0]     sum_q;
	logic [7:0]      held_q;
	logic [CH_W-1:0] ch_q;
	logic            out_valid_q;
	logic            status_q;
	logic [3:0]      index_q;
	logic [15:0]     value_q;
	logic            last_q;
	logic [15:0]     store [CHANNELS];

	unit_req_t       req;
	unit_rsp_t       rsp;
	logic [5:0]      off;
	logic            cfg_wr;

	rcsfp_unit u_unit (
		.req(req),
		.rsp(rsp)
	);

	assign off    = count_q - 6'd2;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? {24'h000000, second_hdr_q} : {24'h000000, first_hdr_q};

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign channel_index = index_q;
	assign channel_value = value_q;
	assign last_of_run   = last_q;

	always_comb begin
		req.a = sum_q;
		req.b = {8'h00, byte_q};
		if (state_q == S_TEST) begin
			case (phase_q)
				PH_HDR2: begin
					req.a = {8'h00, byte_q};
					req.b = {8'h00, second_hdr_q};
				end
				PH_BODY: begin
					if (count_q > SUM_END) begin
						req.a = {byte_q, held_q};
						req.b = sum_q;
					end
				end
				default: begin
					req.a = {8'h00, byte_q};
					req.b = {8'h00, first_hdr_q};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_hdr_q  <= 8'd32;
			second_hdr_q <= 8'd64;
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				second_hdr_q <= pwdata[7:0];
			end else begin
				first_hdr_q <= pwdata[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_HDR1;
			count_q     <= 6'd0;
			sum_q       <= 16'hFFFF;
			held_q      <= 8'h00;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_TEST;
					end
				end
				S_TEST: begin
					state_q <= S_IDLE;
					case (phase_q)
						PH_HDR2: begin
							if (rsp.eq) begin
								phase_q <= PH_BODY;
								count_q <= 6'd2;
								state_q <= S_SUM;
							end else begin
								phase_q <= PH_HDR1;
							end
						end
						PH_BODY: begin
							count_q <= count_q + 6'd1;
							if (count_q < SUM_END) begin
								sum_q <= rsp.diff;
								if (count_q >= 6'd2 && count_q < CAP_END && !off[0]) begin
									held_q <= byte_q;
								end
							end else if (count_q == SUM_END) begin
								held_q <= byte_q;
							end else begin
								phase_q <= PH_HDR1;
								if (rsp.eq) begin
									ch_q    <= '0;
									state_q <= S_LOAD;
								end else begin
									out_valid_q <= 1'b1;
									state_q     <= S_SEND;
								end
							end
						end
						default: begin
							if (rsp.eq) begin
								phase_q <= PH_HDR2;
								count_q <= 6'd1;
								sum_q   <= 16'hFFFF;
								state_q <= S_SUM;
							end
						end
					endcase
				end
				S_SUM: begin
					sum_q   <= rsp.diff;
					state_q <= S_IDLE;
				end
				S_LOAD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_SEND;
				end
				S_SEND: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_LOAD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_TEST && phase_q == PH_BODY && count_q < SUM_END &&
				count_q >= 6'd2 && count_q < CAP_END && off[0]) begin
			store[off[CH_W:1]] <= {byte_q, held_q};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			byte_q <= rx_byte;
		end
		if (state_q == S_LOAD) begin
			status_q <= 1'b0;
			index_q  <= 4'(ch_q);
			value_q  <= store[ch_q];
			last_q   <= (ch_q == LAST_CH);
		end else if (state_q == S_TEST) begin
			status_q <= 1'b1;
			index_q  <= 4'd0;
			value_q  <= 16'h0000;
			last_q   <= 1'b1;
		end
	end

	`RCSFP_ASSERT_NOW(a_no_take_while_pending, clk, arst_n, in_ready, !out_valid)
	`RCSFP_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)
	`RCSFP_ASSERT_NEXT(a_free_after_last, clk, arst_n, out_valid && out_ready && last_of_run, in_ready)
	`RCSFP_ASSERT_NOW(a_error_word_shape, clk, arst_n, out_valid && status, last_of_run && channel_value == 16'h0000 && channel_index == 4'd0)
	`RCSFP_ASSERT_NOW(a_index_in_range, clk, arst_n, out_valid && !status, channel_index <= 4'(CHANNELS - 1))

endmodule
